>>> hdl/utf8d_pkg.sv
// Shared types, constants and byte classing for the UTF-8 stream decoder.
`default_nettype none
package utf8d_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw    = $clog2(QDepth);
  localparam int unsigned CpW    = 21;
  localparam int unsigned UsedW  = 3;

  localparam logic [5:0] ContMask = 6'h3f;

  typedef enum logic [2:0] {
    CLS_CONT,
    CLS_ASCII,
    CLS_LEAD2,
    CLS_LEAD3,
    CLS_LEAD4,
    CLS_ILLEGAL
  } byte_class_e;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_VALID,
    TAIL_BAD
  } tail_e;

  // One decoded input byte: n_bad invalid words first, then an optional tail word.
  typedef struct packed {
    logic [1:0]       n_bad;
    tail_e            tail;
    logic [CpW-1:0]   cp;
    logic [UsedW-1:0] used;
    logic             eot;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } q_head_t;

  // Class a byte by its top five bits.
  function automatic byte_class_e class_of(input logic [7:0] b);
    byte_class_e k;
    case (b[7:3])
      5'b11000, 5'b11001, 5'b11010, 5'b11011: k = CLS_LEAD2;
      5'b11100, 5'b11101:                     k = CLS_LEAD3;
      5'b11110:                               k = CLS_LEAD4;
      5'b11111:                               k = CLS_ILLEGAL;
      default: begin
        if (b[7] == 1'b0) begin
          k = CLS_ASCII;
        end else begin
          k = CLS_CONT;
        end
      end
    endcase
    return k;
  endfunction

  // Continuation bytes still needed after a lead byte.
  function automatic logic [1:0] cont_need(input logic [7:0] lead);
    logic [1:0] n;
    case (class_of(lead))
      CLS_LEAD3: n = 2'd2;
      CLS_LEAD4: n = 2'd3;
      default:   n = 2'd1;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

>>> hdl/utf8d_front.sv
// Front end: classes each input word, tracks the pending sequence, emits jobs.
`default_nettype none
module utf8d_front (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             accept_i,
  input  wire logic [7:0]       byte_i,
  input  wire logic             eot_i,
  output utf8d_pkg::job_t       job_o,
  output logic                  push_o
);

  logic [7:0]  lead_q, lead_d;
  logic        seq_q, seq_d;
  logic [1:0]  count_q, count_d;
  logic [5:0]  cont_q [2];
  logic        cont_we;
  logic        cont_sel;

  utf8d_pkg::byte_class_e kind;
  logic [1:0]  need;
  logic [2:0]  held_next;
  logic        fresh;
  logic [5:0]  c;

  always_comb begin
    kind      = utf8d_pkg::class_of(byte_i);
    need      = utf8d_pkg::cont_need(lead_q);
    held_next = {1'b0, count_q} + 3'd1;
    c         = byte_i[5:0] & utf8d_pkg::ContMask;
    lead_d    = lead_q;
    seq_d     = seq_q;
    count_d   = count_q;
    cont_we   = 1'b0;
    cont_sel  = count_q[0];
    fresh     = 1'b1;
    job_o.n_bad = 2'd0;
    job_o.tail  = utf8d_pkg::TAIL_NONE;
    job_o.cp    = '0;
    job_o.used  = 3'd1;
    job_o.eot   = eot_i;

    if (seq_q) begin
      if (kind == utf8d_pkg::CLS_CONT) begin
        fresh = 1'b0;
        if (held_next >= {1'b0, need}) begin
          // Sequence complete: assemble the scalar value.
          job_o.tail = utf8d_pkg::TAIL_VALID;
          job_o.used = {1'b0, need} + 3'd1;
          case (need)
            2'd1:    job_o.cp = {10'd0, lead_q[4:0], c};
            2'd2:    job_o.cp = {5'd0, lead_q[3:0], cont_q[0], c};
            default: job_o.cp = {lead_q[2:0], cont_q[0], cont_q[1], c};
          endcase
          seq_d   = 1'b0;
          count_d = 2'd0;
        end else begin
          cont_we = 1'b1;
          count_d = held_next[1:0];
          if (eot_i) begin
            // Cut off: the lead plus every held continuation is bad.
            job_o.n_bad = held_next[1:0] + 2'd1;
          end
        end
      end else begin
        // Broken sequence: flush lead and held continuations.
        job_o.n_bad = count_q + 2'd1;
        seq_d       = 1'b0;
        count_d     = 2'd0;
      end
    end

    if (fresh) begin
      case (kind)
        utf8d_pkg::CLS_ASCII: begin
          job_o.tail = utf8d_pkg::TAIL_VALID;
          job_o.cp   = {13'd0, byte_i};
        end
        utf8d_pkg::CLS_CONT, utf8d_pkg::CLS_ILLEGAL: begin
          job_o.tail = utf8d_pkg::TAIL_BAD;
        end
        default: begin
          if (eot_i) begin
            job_o.tail = utf8d_pkg::TAIL_BAD;
          end else begin
            lead_d  = byte_i;
            seq_d   = 1'b1;
            count_d = 2'd0;
          end
        end
      endcase
    end

    if (eot_i) begin
      seq_d   = 1'b0;
      count_d = 2'd0;
    end

    push_o = accept_i && ((job_o.n_bad != 2'd0) || (job_o.tail != utf8d_pkg::TAIL_NONE));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q  <= 8'd0;
      seq_q   <= 1'b0;
      count_q <= 2'd0;
    end else if (accept_i) begin
      lead_q  <= lead_d;
      seq_q   <= seq_d;
      count_q <= count_d;
    end
  end

  // Continuation payloads: no reset, only read once written in this sequence.
  always_ff @(posedge clk_i) begin
    if (accept_i && cont_we) begin
      cont_q[cont_sel] <= c;
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8d_queue.sv
// Short job queue between the front end and the result sequencer.
`default_nettype none
module utf8d_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire utf8d_pkg::job_t  job_i,
  input  wire logic             pop_i,
  output utf8d_pkg::q_head_t    head_o,
  output logic                  full_o
);

  localparam logic [utf8d_pkg::QAw:0] Depth = (utf8d_pkg::QAw + 1)'(utf8d_pkg::QDepth);

  utf8d_pkg::job_t                 mem_q [utf8d_pkg::QDepth];
  logic [utf8d_pkg::QAw-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [utf8d_pkg::QAw:0]         cnt_q, cnt_d;
  logic                            do_push, do_pop;

  always_comb begin
    do_push = push_i && (cnt_q != Depth);
    do_pop  = pop_i && (cnt_q != '0);
    wr_d    = do_push ? wr_q + 1'b1 : wr_q;
    rd_d    = do_pop ? rd_q + 1'b1 : rd_q;
    cnt_d   = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
    full_o       = (cnt_q == Depth);
    head_o.valid = (cnt_q != '0);
    head_o.job   = mem_q[rd_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule
`default_nettype wire

>>> hdl/utf8d_back.sv
// Back end: expands each job into result words behind an output register.
`default_nettype none
module utf8d_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire utf8d_pkg::q_head_t            head_i,
  output logic                               pop_o,
  output logic                               valid_o,
  input  wire logic                          ready_i,
  output logic [utf8d_pkg::CpW-1:0]          cp_o,
  output logic                               invalid_o,
  output logic [utf8d_pkg::UsedW-1:0]        used_o,
  output logic                               last_o,
  output logic                               done_o
);

  logic [1:0] idx_q, idx_d;
  logic [2:0] total;
  logic       is_last, load, in_flush;

  logic                        valid_q;
  logic [utf8d_pkg::CpW-1:0]   cp_q, cp_d;
  logic                        inv_q, inv_d;
  logic [utf8d_pkg::UsedW-1:0] used_q, used_d;
  logic                        last_q, done_q;

  always_comb begin
    total    = {1'b0, head_i.job.n_bad} +
               ((head_i.job.tail != utf8d_pkg::TAIL_NONE) ? 3'd1 : 3'd0);
    is_last  = ({1'b0, idx_q} + 3'd1) == total;
    load     = head_i.valid && (!valid_q || ready_i);
    pop_o    = load && is_last;
    idx_d    = idx_q;
    if (load) begin
      idx_d = is_last ? 2'd0 : idx_q + 2'd1;
    end
    in_flush = idx_q < head_i.job.n_bad;
    cp_d     = '0;
    inv_d    = 1'b1;
    used_d   = 3'd1;
    if (!in_flush && (head_i.job.tail == utf8d_pkg::TAIL_VALID)) begin
      cp_d   = head_i.job.cp;
      inv_d  = 1'b0;
      used_d = head_i.job.used;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= 2'd0;
      valid_q <= 1'b0;
      last_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      idx_q <= idx_d;
      if (load) begin
        valid_q <= 1'b1;
        last_q  <= is_last;
        done_q  <= is_last && head_i.job.eot;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= cp_d;
      inv_q  <= inv_d;
      used_q <= used_d;
    end
  end

  assign valid_o   = valid_q;
  assign cp_o      = cp_q;
  assign invalid_o = inv_q;
  assign used_o    = used_q;
  assign last_o    = last_q;
  assign done_o    = done_q;

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && done_q |-> last_q)
    else $error("text end flagged on a word that does not close its run");

  a_bad_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && inv_q |-> (cp_q == '0) && (used_q == 3'd1))
    else $error("invalid word carries a value or a length");

  a_idx_in_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_i.valid |-> ({1'b0, idx_q} < total))
    else $error("word index ran past the job's word count");

  a_idle_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !head_i.valid |-> idx_q == 2'd0)
    else $error("word index left set with no job pending");

endmodule
`default_nettype wire

>>> hdl/utf8_stream_decoder.sv
// Top level of the streaming UTF-8 decoder: byte words in, code point words out.
//
//  channel  dir  tdata                               tlast        tuser
//  s_axis   in   [7:0] data_byte                     end_of_text  -
//  m_axis   out  [20:0] code_point, [23:21] bytes    last_of_run  [0] invalid,
//                                                                 [1] text_done
//
// The front end takes one byte word per cycle as long as the job queue
// (four entries) has room; ready depends on queue occupancy only.
// Each byte that yields results becomes one job; the back end sends one
// result word per cycle unless m_axis stalls, so a byte yields 1 to 4 words.
// A non-final lead byte with no sequence pending yields no job and no words.
// The output register decouples m_axis stalls from the front end; stalls on
// either side only hold data, never drop or repeat a word.
// Reset clears sequence state, the queue and the output register's flags at once.
`default_nettype none
module utf8_stream_decoder (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  wire logic        s_axis_tlast,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [23:0]      m_axis_tdata,   // [20:0] code_point, [23:21] bytes_used
  output logic             m_axis_tlast,   // last_of_run
  output logic [1:0]       m_axis_tuser    // [0] invalid, [1] text_done
);

  utf8d_pkg::job_t    job;
  utf8d_pkg::q_head_t head;
  logic               push, pop, full, accept;
  logic [utf8d_pkg::CpW-1:0]   cp;
  logic [utf8d_pkg::UsedW-1:0] used;
  logic               inv, done;

  // Accept a byte whenever the queue can take a job.
  assign s_axis_tready = !full;
  assign accept        = s_axis_tvalid && !full;

  utf8d_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (s_axis_tdata),
    .eot_i    (s_axis_tlast),
    .job_o    (job),
    .push_o   (push)
  );

  utf8d_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job),
    .pop_i  (pop),
    .head_o (head),
    .full_o (full)
  );

  utf8d_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .pop_o     (pop),
    .valid_o   (m_axis_tvalid),
    .ready_i   (m_axis_tready),
    .cp_o      (cp),
    .invalid_o (inv),
    .used_o    (used),
    .last_o    (m_axis_tlast),
    .done_o    (done)
  );

  // Pack result fields, highest field first.
  assign m_axis_tdata = {used, cp};
  assign m_axis_tuser = {done, inv};

endmodule
`default_nettype wire
